// File: hw/rtl/tvsc_pkg.sv
package tvsc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int COEF_A_W   = 49;
    localparam int COEF_W     = 34;
    localparam int VOL_W      = 48;

    // internal widths follow from the coordinate width
    localparam int MINOR_W   = 2 * COORD_BITS + 1;
    localparam int PROD_W    = 3 * COORD_BITS + 1;
    localparam int DXYZ_W    = PROD_W + 2;
    localparam int ACC_W     = MINOR_W + 2;
    localparam int DET_W     = DXYZ_W + 2;
    localparam int DIV_W     = ((DET_W + 7) / 8) * 8;
    localparam int DIV_CYC   = DIV_W / 8;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);
    localparam int SAT_A_W   = DXYZ_W + COEF_A_W + 1;
    localparam int SAT_C_W   = ACC_W + COEF_W + 1;

    localparam logic [3:0] DIVISOR = 4'd6;

    localparam logic [2:0] ADDR_ELEMENT_COUNT = 3'd0;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [2:0] {
        STEP_S0,
        STEP_S1,
        STEP_S2,
        STEP_S3,
        STEP_S4
    } t_step;

    typedef struct packed {
        logic       load;
        logic       node_en;
        t_step      step;
        logic [1:0] node;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        logic [1:0] out_idx;
        logic       out_batch_end;
    } t_dp_cmd;

    function automatic t_coord to_coord(input logic [FIELD_W-1:0] f);
        logic [COORD_BITS+FIELD_W-1:0] t;
        t = {{COORD_BITS{1'b0}}, f};
        return t_coord'(t[COORD_BITS-1:0]);
    endfunction

    // k-th of the three nodes other than n, in increasing order
    function automatic logic [1:0] other_node(input logic [1:0] n, input logic [1:0] k);
        return (k < n) ? k : k + 2'd1;
    endfunction

    function automatic logic [COEF_A_W-1:0] sat_a(input logic signed [DXYZ_W:0] v);
        logic signed [SAT_A_W-1:0] w;
        logic signed [SAT_A_W-1:0] hi;
        logic signed [SAT_A_W-1:0] lo;
        w  = SAT_A_W'(v);
        hi = (SAT_A_W'(1) <<< (COEF_A_W - 1)) - SAT_A_W'(1);
        lo = -hi - SAT_A_W'(1);
        if (w > hi) begin
            w = hi;
        end else if (w < lo) begin
            w = lo;
        end
        return w[COEF_A_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] sat_c(input logic signed [ACC_W:0] v);
        logic signed [SAT_C_W-1:0] w;
        logic signed [SAT_C_W-1:0] hi;
        logic signed [SAT_C_W-1:0] lo;
        w  = SAT_C_W'(v);
        hi = (SAT_C_W'(1) <<< (COEF_W - 1)) - SAT_C_W'(1);
        lo = -hi - SAT_C_W'(1);
        if (w > hi) begin
            w = hi;
        end else if (w < lo) begin
            w = lo;
        end
        return w[COEF_W-1:0];
    endfunction

    function automatic logic [VOL_W-1:0] sat_vol(input logic [DIV_W-1:0] q);
        logic [DIV_W+VOL_W-1:0] t;
        t = {{VOL_W{1'b0}}, q};
        if (|t[DIV_W+VOL_W-1:VOL_W]) begin
            return '1;
        end
        return t[VOL_W-1:0];
    endfunction

endpackage

// File: hw/rtl/tvsc_if.sv
interface tvsc_elem_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] node0_x;
    logic signed [15:0] node0_y;
    logic signed [15:0] node0_z;
    logic signed [15:0] node1_x;
    logic signed [15:0] node1_y;
    logic signed [15:0] node1_z;
    logic signed [15:0] node2_x;
    logic signed [15:0] node2_y;
    logic signed [15:0] node2_z;
    logic signed [15:0] node3_x;
    logic signed [15:0] node3_y;
    logic signed [15:0] node3_z;

    modport source (
        output valid, node0_x, node0_y, node0_z, node1_x, node1_y, node1_z,
               node2_x, node2_y, node2_z, node3_x, node3_y, node3_z,
        input  ready
    );
    modport sink (
        input  valid, node0_x, node0_y, node0_z, node1_x, node1_y, node1_z,
               node2_x, node2_y, node2_z, node3_x, node3_y, node3_z,
        output ready
    );
endinterface

interface tvsc_coef_if;
    logic               valid;
    logic               ready;
    logic [1:0]         node_index;
    logic signed [48:0] coef_a;
    logic signed [33:0] coef_b;
    logic signed [33:0] coef_c;
    logic signed [33:0] coef_d;
    logic [47:0]        volume;
    logic               element_last;
    logic               batch_end;

    modport source (
        output valid, node_index, coef_a, coef_b, coef_c, coef_d, volume,
               element_last, batch_end,
        input  ready
    );
    modport sink (
        input  valid, node_index, coef_a, coef_b, coef_c, coef_d, volume,
               element_last, batch_end,
        output ready
    );
endinterface

// File: hw/rtl/tvsc_dp.sv
module tvsc_dp (
    input  logic                                  i_clk,
    input  tvsc_pkg::t_dp_cmd                     i_cmd,
    input  logic [3:0][tvsc_pkg::FIELD_W-1:0]     i_x,
    input  logic [3:0][tvsc_pkg::FIELD_W-1:0]     i_y,
    input  logic [3:0][tvsc_pkg::FIELD_W-1:0]     i_z,
    output logic [1:0]                            o_node_index,
    output logic [tvsc_pkg::COEF_A_W-1:0]         o_coef_a,
    output logic [tvsc_pkg::COEF_W-1:0]           o_coef_b,
    output logic [tvsc_pkg::COEF_W-1:0]           o_coef_c,
    output logic [tvsc_pkg::COEF_W-1:0]           o_coef_d,
    output logic [tvsc_pkg::VOL_W-1:0]            o_volume,
    output logic                                  o_element_last,
    output logic                                  o_batch_end
);
    import tvsc_pkg::*;

    t_coord r_x [4];
    t_coord r_y [4];
    t_coord r_z [4];

    logic signed [MINOR_W-1:0] r_myz, r_mxz, r_mxy;
    logic signed [ACC_W-1:0]   r_acc_yz, r_acc_xz, r_acc_xy;
    logic signed [PROD_W-1:0]  r_px, r_py, r_pz;
    logic signed [DXYZ_W-1:0]  r_ra;
    logic signed [DET_W-1:0]   r_det;
    logic [DIV_W-1:0]          r_dv;
    logic [2:0]                r_rem;

    logic [COEF_A_W-1:0] r_na [4];
    logic [COEF_W-1:0]   r_nb [4];
    logic [COEF_W-1:0]   r_nc [4];
    logic [COEF_W-1:0]   r_nd [4];

    logic [1:0] w_r0, w_r1, w_r2, w_p, w_q;
    logic signed [MINOR_W-1:0] w_myz, w_mxz, w_mxy;
    logic signed [PROD_W-1:0]  w_px, w_py, w_pz;
    logic signed [DXYZ_W:0]    w_a_full;
    logic signed [ACC_W:0]     w_b_full, w_c_full, w_d_full;
    logic signed [DET_W-1:0]   w_abs;
    logic [DIV_W-1:0]          w_dv;
    logic [2:0]                w_rem;
    logic [3:0]                w_t;

    assign w_r0 = other_node(i_cmd.node, 2'd0);
    assign w_r1 = other_node(i_cmd.node, 2'd1);
    assign w_r2 = other_node(i_cmd.node, 2'd2);

    // pair of rows whose 2x2 minors are formed this step
    always_comb begin
        case (i_cmd.step)
            STEP_S0: begin
                w_p = w_r1;
                w_q = w_r2;
            end
            STEP_S1: begin
                w_p = w_r0;
                w_q = w_r2;
            end
            default: begin
                w_p = w_r0;
                w_q = w_r1;
            end
        endcase
    end

    assign w_myz = MINOR_W'(r_y[w_p]) * MINOR_W'(r_z[w_q])
                 - MINOR_W'(r_z[w_p]) * MINOR_W'(r_y[w_q]);
    assign w_mxz = MINOR_W'(r_x[w_p]) * MINOR_W'(r_z[w_q])
                 - MINOR_W'(r_z[w_p]) * MINOR_W'(r_x[w_q]);
    assign w_mxy = MINOR_W'(r_x[w_p]) * MINOR_W'(r_y[w_q])
                 - MINOR_W'(r_y[w_p]) * MINOR_W'(r_x[w_q]);

    // cofactor expansion along the first remaining row
    assign w_px = PROD_W'(r_x[w_r0]) * PROD_W'(r_myz);
    assign w_py = PROD_W'(r_y[w_r0]) * PROD_W'(r_mxz);
    assign w_pz = PROD_W'(r_z[w_r0]) * PROD_W'(r_mxy);

    // odd nodes negate a and c, even nodes negate b and d
    assign w_a_full = i_cmd.node[0] ? -(DXYZ_W + 1)'(r_ra) : (DXYZ_W + 1)'(r_ra);
    assign w_b_full = i_cmd.node[0] ? (ACC_W + 1)'(r_acc_yz) : -(ACC_W + 1)'(r_acc_yz);
    assign w_c_full = i_cmd.node[0] ? -(ACC_W + 1)'(r_acc_xz) : (ACC_W + 1)'(r_acc_xz);
    assign w_d_full = i_cmd.node[0] ? (ACC_W + 1)'(r_acc_xy) : -(ACC_W + 1)'(r_acc_xy);

    assign w_abs = r_det[DET_W-1] ? -r_det : r_det;

    // eight bits of restoring division by six per cycle
    always_comb begin
        w_dv  = r_dv;
        w_rem = r_rem;
        w_t   = '0;
        for (int i = 0; i < 8; i++) begin
            w_t  = {w_rem, w_dv[DIV_W-1]};
            w_dv = {w_dv[DIV_W-2:0], 1'b0};
            if (w_t >= DIVISOR) begin
                w_rem   = 3'(w_t - DIVISOR);
                w_dv[0] = 1'b1;
            end else begin
                w_rem = w_t[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int n = 0; n < 4; n++) begin
                r_x[n] <= to_coord(i_x[n]);
                r_y[n] <= to_coord(i_y[n]);
                r_z[n] <= to_coord(i_z[n]);
            end
        end
        if (i_cmd.node_en) begin
            r_myz <= w_myz;
            r_mxz <= w_mxz;
            r_mxy <= w_mxy;
            case (i_cmd.step)
                STEP_S1: begin
                    r_acc_yz <= ACC_W'(r_myz);
                    r_acc_xz <= ACC_W'(r_mxz);
                    r_acc_xy <= ACC_W'(r_mxy);
                    r_px     <= w_px;
                    r_py     <= w_py;
                    r_pz     <= w_pz;
                end
                STEP_S2: begin
                    r_acc_yz <= r_acc_yz - ACC_W'(r_myz);
                    r_acc_xz <= r_acc_xz - ACC_W'(r_mxz);
                    r_acc_xy <= r_acc_xy - ACC_W'(r_mxy);
                    r_ra     <= DXYZ_W'(r_px) - DXYZ_W'(r_py) + DXYZ_W'(r_pz);
                end
                STEP_S3: begin
                    r_acc_yz <= r_acc_yz + ACC_W'(r_myz);
                    r_acc_xz <= r_acc_xz + ACC_W'(r_mxz);
                    r_acc_xy <= r_acc_xy + ACC_W'(r_mxy);
                end
                STEP_S4: begin
                    r_na[i_cmd.node] <= sat_a(w_a_full);
                    r_nb[i_cmd.node] <= sat_c(w_b_full);
                    r_nc[i_cmd.node] <= sat_c(w_c_full);
                    r_nd[i_cmd.node] <= sat_c(w_d_full);
                    r_det <= ((i_cmd.node == 2'd0) ? '0 : r_det) + DET_W'(w_a_full);
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.div_init) begin
            r_dv  <= DIV_W'($unsigned(w_abs));
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dv  <= w_dv;
            r_rem <= w_rem;
        end
        if (i_cmd.out_load) begin
            o_node_index   <= i_cmd.out_idx;
            o_coef_a       <= r_na[i_cmd.out_idx];
            o_coef_b       <= r_nb[i_cmd.out_idx];
            o_coef_c       <= r_nc[i_cmd.out_idx];
            o_coef_d       <= r_nd[i_cmd.out_idx];
            o_volume       <= sat_vol(r_dv);
            o_element_last <= (i_cmd.out_idx == 2'd3);
            o_batch_end    <= i_cmd.out_batch_end;
        end
    end

endmodule

// File: hw/rtl/tvsc_ctrl.sv
module tvsc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [tvsc_pkg::COUNT_W-1:0]  i_element_count,
    output tvsc_pkg::t_dp_cmd             o_cmd
);
    import tvsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE,
        ST_ABS,
        ST_DIV,
        ST_PRESENT,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [1:0]            r_node;
    t_step                 r_step;
    t_step                 n_step;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [1:0]            r_out_idx;
    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_counter;
    logic                  r_last_batch;

    logic [COUNT_W:0]      w_limit;
    logic                  w_last;
    logic                  w_accept;

    assign w_limit  = (i_element_count == '0) ? (COUNT_W + 1)'(1)
                                              : {1'b0, i_element_count};
    assign w_last   = ({1'b0, r_counter} + (COUNT_W + 1)'(1)) >= w_limit;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_step)
            STEP_S0: n_step = STEP_S1;
            STEP_S1: n_step = STEP_S2;
            STEP_S2: n_step = STEP_S3;
            STEP_S3: n_step = STEP_S4;
            default: n_step = STEP_S0;
        endcase
    end

    always_comb begin
        o_cmd               = '0;
        o_cmd.load          = w_accept;
        o_cmd.node_en       = (r_state == ST_NODE);
        o_cmd.step          = r_step;
        o_cmd.node          = r_node;
        o_cmd.div_init      = (r_state == ST_ABS);
        o_cmd.div_step      = (r_state == ST_DIV);
        o_cmd.out_load      = (r_state == ST_PRESENT);
        o_cmd.out_idx       = r_out_idx;
        o_cmd.out_batch_end = r_last_batch && (r_out_idx == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node       <= '0;
            r_step       <= STEP_S0;
            r_div_cnt    <= '0;
            r_out_idx    <= '0;
            r_out_valid  <= 1'b0;
            r_counter    <= '0;
            r_last_batch <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state      <= ST_NODE;
                        r_node       <= '0;
                        r_step       <= STEP_S0;
                        r_last_batch <= w_last;
                        r_counter    <= w_last ? '0 : r_counter + COUNT_W'(1);
                    end
                end
                ST_NODE: begin
                    r_step <= n_step;
                    if (r_step == STEP_S4) begin
                        if (r_node == 2'd3) begin
                            r_state <= ST_ABS;
                        end else begin
                            r_node <= r_node + 2'd1;
                        end
                    end
                end
                ST_ABS: begin
                    r_state   <= ST_DIV;
                    r_div_cnt <= '0;
                end
                ST_DIV: begin
                    if (r_div_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                        r_state   <= ST_PRESENT;
                        r_out_idx <= '0;
                    end else begin
                        r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    end
                end
                ST_PRESENT: begin
                    r_state     <= ST_EMIT;
                    r_out_valid <= 1'b1;
                end
                ST_EMIT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_idx == 2'd3) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_out_idx <= r_out_idx + 2'd1;
                            r_state   <= ST_PRESENT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_valid_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EMIT))
        else $error("result valid outside emit state");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_out_valid)
        else $error("request taken while results pending");

    a_last_node_to_abs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NODE && r_step == STEP_S4 && r_node == 2'd3) |=> (r_state == ST_ABS))
        else $error("node sweep did not end in volume stage");

    a_batch_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_counter == '0))
        else $error("batch counter did not wrap");

endmodule

// File: hw/rtl/tetra_volume_shape_coefficients.sv
// Linear tetrahedron shape-function coefficients.
// Input channel i_elem: one request per element, the x/y/z coordinates of its
// four nodes. Output channel o_coef: four results per element, nodes 0..3 in
// order, each with coefficients a, b, c, d and the element volume;
// element_last marks the fourth result, batch_end marks the fourth result of
// the last element of a batch of element_count elements.
// One element at a time: a shared set of six 2x2-minor multipliers and three
// expansion multipliers runs steps S0 to S4 for each node in turn, the
// absolute determinant is divided by six 8 bits per cycle, then each result is
// loaded into the output register in a present state and offered in an emit
// state. i_elem.ready is high only while the block is idle.
// A stalled receiver holds the current result in its output register and the
// block waits; nothing is dropped.
// Reset (synchronous, active low) returns to idle, clears the batch counter
// and sets element_count to 1. element_count is written over the APB port at
// byte address 0; the user must write it only while the block is idle, and the
// block itself does not enforce this; pready is always high.
module tetra_volume_shape_coefficients (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tvsc_elem_if.sink          i_elem,
    tvsc_coef_if.source        o_coef,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tvsc_pkg::*;

    logic [COUNT_W-1:0]       r_element_count;
    t_dp_cmd                  w_cmd;
    logic                     w_in_ready;
    logic                     w_out_valid;
    logic [3:0][FIELD_W-1:0]  w_x, w_y, w_z;
    logic [1:0]               w_node_index;
    logic [COEF_A_W-1:0]      w_coef_a;
    logic [COEF_W-1:0]        w_coef_b, w_coef_c, w_coef_d;
    logic [VOL_W-1:0]         w_volume;
    logic                     w_element_last;
    logic                     w_batch_end;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ELEMENT_COUNT) ? {16'b0, r_element_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= COUNT_W'(1);
        end else if (psel && penable && pwrite && paddr == ADDR_ELEMENT_COUNT) begin
            r_element_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign w_x = {i_elem.node3_x, i_elem.node2_x, i_elem.node1_x, i_elem.node0_x};
    assign w_y = {i_elem.node3_y, i_elem.node2_y, i_elem.node1_y, i_elem.node0_y};
    assign w_z = {i_elem.node3_z, i_elem.node2_z, i_elem.node1_z, i_elem.node0_z};

    tvsc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_elem.valid),
        .o_in_ready      (w_in_ready),
        .o_out_valid     (w_out_valid),
        .i_out_ready     (o_coef.ready),
        .i_element_count (r_element_count),
        .o_cmd           (w_cmd)
    );

    tvsc_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_x            (w_x),
        .i_y            (w_y),
        .i_z            (w_z),
        .o_node_index   (w_node_index),
        .o_coef_a       (w_coef_a),
        .o_coef_b       (w_coef_b),
        .o_coef_c       (w_coef_c),
        .o_coef_d       (w_coef_d),
        .o_volume       (w_volume),
        .o_element_last (w_element_last),
        .o_batch_end    (w_batch_end)
    );

    assign i_elem.ready        = w_in_ready;
    assign o_coef.valid        = w_out_valid;
    assign o_coef.node_index   = w_node_index;
    assign o_coef.coef_a       = w_coef_a;
    assign o_coef.coef_b       = w_coef_b;
    assign o_coef.coef_c       = w_coef_c;
    assign o_coef.coef_d       = w_coef_d;
    assign o_coef.volume       = w_volume;
    assign o_coef.element_last = w_element_last;
    assign o_coef.batch_end    = w_batch_end;

endmodule
